@@ hw/rtl/ossd_pkg.sv @@
// Package for the overlap SSD patch search.
// Field widths, config register indexes, reset values and the queue entry type.
package ossd_pkg;

  localparam int MAX_TILE       = 64;
  localparam int MAX_SEARCH_DIM = 4096;
  localparam int QUEUE_DEPTH    = 4;

  localparam int POS_W      = 12;
  localparam int OFF_W      = 6;
  localparam int PIX_W      = 8;
  localparam int COST_W     = 32;
  localparam int MODE_W     = 2;
  localparam int OVL_W      = 6;
  localparam int TILE_DIM_W = 7;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int SQ_W       = 2 * PIX_W;
  localparam int ADD_W      = SQ_W + 2;
  localparam int TILE_CW    = ($clog2(MAX_TILE + 1) > TILE_DIM_W) ?
                              $clog2(MAX_TILE + 1) : TILE_DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_W  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_H  = 2'd3;

  localparam logic [MODE_W-1:0] MODE_TOP  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEFT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BOTH = 2'd2;

  localparam logic [MODE_W-1:0]     RST_MODE   = MODE_BOTH;
  localparam logic [OVL_W-1:0]      RST_OVL    = 6'd6;
  localparam logic [TILE_DIM_W-1:0] RST_TILE_W = 7'd36;
  localparam logic [TILE_DIM_W-1:0] RST_TILE_H = 7'd36;

  typedef struct packed {
    logic [POS_W-1:0] cand_x;
    logic [POS_W-1:0] cand_y;
    logic [ADD_W-1:0] cost;
    logic             done;
    logic             eos;
  } q_entry_t;

endpackage

@@ hw/rtl/ossd_front.sv @@
// Front end: config registers, overlap classification and per-pixel squared error.
// Depends on ossd_pkg.
module ossd_front import ossd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [POS_W-1:0]      cand_x,
  input  logic [POS_W-1:0]      cand_y,
  input  logic [OFF_W-1:0]      off_x,
  input  logic [OFF_W-1:0]      off_y,
  input  logic [PIX_W-1:0]      tex_r,
  input  logic [PIX_W-1:0]      tex_g,
  input  logic [PIX_W-1:0]      tex_b,
  input  logic [PIX_W-1:0]      dst_r,
  input  logic [PIX_W-1:0]      dst_g,
  input  logic [PIX_W-1:0]      dst_b,
  input  logic                  end_of_candidate,
  input  logic                  end_of_search,
  output q_entry_t              entry
);

  logic [MODE_W-1:0]     overlap_mode;
  logic [OVL_W-1:0]      overlap_size;
  logic [TILE_DIM_W-1:0] patch_w;
  logic [TILE_DIM_W-1:0] patch_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      overlap_mode <= RST_MODE;
      overlap_size <= RST_OVL;
      patch_w      <= RST_TILE_W;
      patch_h      <= RST_TILE_H;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   overlap_mode <= cfg_data[MODE_W-1:0];
        REG_OVL:    overlap_size <= cfg_data[OVL_W-1:0];
        REG_TILE_W: patch_w      <= cfg_data[TILE_DIM_W-1:0];
        REG_TILE_H: patch_h      <= cfg_data[TILE_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [SQ_W-1:0] sq_diff(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  logic [TILE_CW-1:0] tw;
  logic [TILE_CW-1:0] th;
  logic               in_tile;
  logic               top_hit;
  logic               left_hit;
  logic               counted;
  logic [ADD_W-1:0]   pix_cost;

  always_comb begin
    tw = (TILE_CW'(patch_w) > TILE_CW'(MAX_TILE)) ? TILE_CW'(MAX_TILE)
                                                   : TILE_CW'(patch_w);
    th = (TILE_CW'(patch_h) > TILE_CW'(MAX_TILE)) ? TILE_CW'(MAX_TILE)
                                                   : TILE_CW'(patch_h);
    in_tile  = (TILE_CW'(off_x) < tw) && (TILE_CW'(off_y) < th);
    top_hit  = off_y < overlap_size;
    left_hit = off_x < overlap_size;
    unique case (overlap_mode)
      MODE_TOP:  counted = in_tile && top_hit;
      MODE_LEFT: counted = in_tile && left_hit;
      default:   counted = in_tile && (top_hit || left_hit);
    endcase
    pix_cost = ADD_W'(sq_diff(tex_r, dst_r)) + ADD_W'(sq_diff(tex_g, dst_g))
             + ADD_W'(sq_diff(tex_b, dst_b));
  end

  always_comb begin
    entry.cand_x = (32'(cand_x) >= MAX_SEARCH_DIM) ? POS_W'(MAX_SEARCH_DIM - 1) : cand_x;
    entry.cand_y = (32'(cand_y) >= MAX_SEARCH_DIM) ? POS_W'(MAX_SEARCH_DIM - 1) : cand_y;
    entry.cost   = counted ? pix_cost : '0;
    entry.done   = end_of_candidate || end_of_search;
    entry.eos    = end_of_search;
  end

endmodule

@@ hw/rtl/ossd_queue.sv @@
// Short FIFO between front and back ends.
// Depends on ossd_pkg for the entry type.
module ossd_queue import ossd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     pop_valid,
  output q_entry_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

@@ hw/rtl/ossd_back.sv @@
// Back end: running SSD per candidate, best-candidate tracking, result register.
// Depends on ossd_pkg.
module ossd_back import ossd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  q_entry_t          q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [POS_W-1:0]  best_x,
  output logic [POS_W-1:0]  best_y,
  output logic [COST_W-1:0] best_cost
);

  logic [COST_W-1:0] running_sum;
  logic [COST_W-1:0] min_cost;
  logic [POS_W-1:0]  min_x;
  logic [POS_W-1:0]  min_y;
  logic              have_min;

  logic [COST_W:0]   sum_ext;
  logic [COST_W-1:0] sum;
  logic              better;
  logic [COST_W-1:0] min_cost_next;
  logic [POS_W-1:0]  min_x_next;
  logic [POS_W-1:0]  min_y_next;

  assign q_pop = q_valid && (!q_data.eos || !out_valid || !out_stall);

  always_comb begin
    sum_ext = {1'b0, running_sum} + (COST_W + 1)'(q_data.cost);
    sum     = sum_ext[COST_W] ? '1 : sum_ext[COST_W-1:0];
    better  = !have_min || (sum < min_cost);
    if (better) begin
      min_cost_next = sum;
      min_x_next    = q_data.cand_x;
      min_y_next    = q_data.cand_y;
    end else begin
      min_cost_next = min_cost;
      min_x_next    = min_x;
      min_y_next    = min_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      min_cost    <= '0;
      min_x       <= '0;
      min_y       <= '0;
      have_min    <= 1'b0;
    end else if (q_pop) begin
      if (q_data.eos) begin
        running_sum <= '0;
        min_cost    <= '0;
        min_x       <= '0;
        min_y       <= '0;
        have_min    <= 1'b0;
      end else if (q_data.done) begin
        running_sum <= '0;
        min_cost    <= min_cost_next;
        min_x       <= min_x_next;
        min_y       <= min_y_next;
        have_min    <= 1'b1;
      end else begin
        running_sum <= sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && q_data.eos) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.eos) begin
      best_x    <= min_x_next;
      best_y    <= min_y_next;
      best_cost <= min_cost_next;
    end
  end

  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_data.eos |=> !have_min && min_cost == '0 && running_sum == '0)
    else $error("search state not cleared after end of search");

  a_done_sets_min: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_data.done && !q_data.eos |=> have_min && running_sum == '0)
    else $error("candidate close did not record a best");

  a_min_monotonic: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_data.done && !q_data.eos && have_min |=>
      min_cost <= $past(min_cost))
    else $error("best cost increased within a search");

  a_no_result_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !(q_pop && q_data.eos))
    else $error("result register overwritten while stalled");

endmodule

@@ hw/rtl/overlap_ssd_best_patch_search.sv @@
// Overlap SSD best-patch search, one pixel pair per clock while in_stall is
// low. The front end classifies each pixel against the configured overlap
// strips and forms the squared RGB error; a short FIFO feeds the back end,
// which accumulates one entry per cycle, keeps the first lowest-cost candidate
// and registers the result. Sustained rate is one item per cycle, set by the
// single-entry accumulate-and-compare step of the back end; the item carrying
// end_of_search passes through the FIFO and, when popped, sets out_valid and
// the result register. A stalled result holds back the FIFO only at the next
// end_of_search. Config must only be written while the block is idle.
module overlap_ssd_best_patch_search import ossd_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [POS_W-1:0]      cand_x,
  input  logic [POS_W-1:0]      cand_y,
  input  logic [OFF_W-1:0]      off_x,
  input  logic [OFF_W-1:0]      off_y,
  input  logic [PIX_W-1:0]      tex_r,
  input  logic [PIX_W-1:0]      tex_g,
  input  logic [PIX_W-1:0]      tex_b,
  input  logic [PIX_W-1:0]      dst_r,
  input  logic [PIX_W-1:0]      dst_g,
  input  logic [PIX_W-1:0]      dst_b,
  input  logic                  end_of_candidate,
  input  logic                  end_of_search,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [POS_W-1:0]      best_x,
  output logic [POS_W-1:0]      best_y,
  output logic [COST_W-1:0]     best_cost
);

  q_entry_t front_entry;
  q_entry_t q_data;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;

  assign in_stall = q_full;

  ossd_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cand_x           (cand_x),
    .cand_y           (cand_y),
    .off_x            (off_x),
    .off_y            (off_y),
    .tex_r            (tex_r),
    .tex_g            (tex_g),
    .tex_b            (tex_b),
    .dst_r            (dst_r),
    .dst_g            (dst_g),
    .dst_b            (dst_b),
    .end_of_candidate (end_of_candidate),
    .end_of_search    (end_of_search),
    .entry            (front_entry)
  );

  ossd_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  ossd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .best_x    (best_x),
    .best_y    (best_y),
    .best_cost (best_cost)
  );

endmodule

@@ dv/overlap_ssd_best_patch_search_tb.sv @@
// Self-checking bench for overlap_ssd_best_patch_search: streams pixel pairs, predicts each
// search's best position and SSD cost, and checks every result transfer in order.
// Depends on ossd_pkg and the overlap_ssd_best_patch_search RTL only.
module overlap_ssd_best_patch_search_tb;
  import ossd_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = QUEUE_DEPTH + 8;
  localparam int RANDOM_ITEMS = 1000;
  localparam int FULL_ROWS    = MAX_TILE / 4;
  localparam logic [MODE_W-1:0] MODE_ALIAS = 2'd3;  // decodes as both strips

  typedef struct {
    logic [POS_W-1:0] cx, cy;
    logic [OFF_W-1:0] ox, oy;
    logic [PIX_W-1:0] tr, tg, tb, dr, dg, db;
    logic             eoc, eos;
  } pix_pair_t;

  typedef struct {
    logic [POS_W-1:0]  x, y;
    logic [COST_W-1:0] cost;
  } best_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [POS_W-1:0]      cand_x, cand_y;
  logic [OFF_W-1:0]      off_x, off_y;
  logic [PIX_W-1:0]      tex_r, tex_g, tex_b, dst_r, dst_g, dst_b;
  logic                  end_of_candidate, end_of_search;
  logic                  out_valid;
  logic                  out_stall;
  logic [POS_W-1:0]      best_x, best_y;
  logic [COST_W-1:0]     best_cost;

  overlap_ssd_best_patch_search i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cand_x(cand_x), .cand_y(cand_y), .off_x(off_x), .off_y(off_y),
    .tex_r(tex_r), .tex_g(tex_g), .tex_b(tex_b),
    .dst_r(dst_r), .dst_g(dst_g), .dst_b(dst_b),
    .end_of_candidate(end_of_candidate), .end_of_search(end_of_search),
    .out_valid(out_valid), .out_stall(out_stall),
    .best_x(best_x), .best_y(best_y), .best_cost(best_cost)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and its copy of the registers
  logic [MODE_W-1:0]     cfg_mode = RST_MODE;
  logic [OVL_W-1:0]      cfg_ovl  = RST_OVL;
  logic [TILE_DIM_W-1:0] cfg_tw   = RST_TILE_W;
  logic [TILE_DIM_W-1:0] cfg_th   = RST_TILE_H;
  logic [COST_W-1:0]     acc_sum  = '0;
  logic [COST_W-1:0]     low_cost = '0;
  logic [POS_W-1:0]      low_x    = '0;
  logic [POS_W-1:0]      low_y    = '0;
  logic                  have_low = 1'b0;

  best_t best_q[$];
  int    n_items = 0;
  int    n_searches = 0;
  int    n_results = 0;
  int    n_writes = 0;
  int    n_fail = 0;
  int    n_cycles = 0;
  int    stall_left = 0;
  bit    quiet = 1'b0;

  function automatic int burst_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SQ_W-1:0] sq_err(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  function automatic logic strip_hit(input logic [OFF_W-1:0] ox, input logic [OFF_W-1:0] oy);
    logic [TILE_DIM_W-1:0] tw, th;
    logic                  top, left;
    tw = (cfg_tw > MAX_TILE) ? TILE_DIM_W'(MAX_TILE) : cfg_tw;
    th = (cfg_th > MAX_TILE) ? TILE_DIM_W'(MAX_TILE) : cfg_th;
    if (ox >= tw || oy >= th) return 1'b0;
    top  = oy < cfg_ovl;
    left = ox < cfg_ovl;
    case (cfg_mode)
      MODE_TOP:  return top;
      MODE_LEFT: return left;
      default:   return top || left;
    endcase
  endfunction

  // fold one accepted transfer into the search state
  task automatic fold_pair(input pix_pair_t p);
    logic [COST_W:0] total;
    best_t           res;
    total = {1'b0, acc_sum};
    if (strip_hit(p.ox, p.oy))
      total = total + sq_err(p.tr, p.dr) + sq_err(p.tg, p.dg) + sq_err(p.tb, p.db);
    if (total[COST_W]) total = {1'b0, {COST_W{1'b1}}};
    if (p.eoc || p.eos) begin
      if (!have_low || total[COST_W-1:0] < low_cost) begin
        low_cost = total[COST_W-1:0];
        low_x    = p.cx;  // 12-bit positions never exceed the search area
        low_y    = p.cy;
        have_low = 1'b1;
      end
      acc_sum = '0;
    end else begin
      acc_sum = total[COST_W-1:0];
    end
    if (p.eos) begin
      res.x = low_x;
      res.y = low_y;
      res.cost = low_cost;
      best_q.push_back(res);
      have_low = 1'b0;
      low_cost = '0;
      low_x = '0;
      low_y = '0;
      n_searches++;
    end
  endtask

  // called at a falling edge, returns at a falling edge; valid stays high on back-to-back
  task automatic send_pair(input pix_pair_t p);
    int gap;
    gap = (quiet || $urandom_range(0, 3) != 0) ? 0 : burst_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cand_x <= p.cx;
    cand_y <= p.cy;
    off_x <= p.ox;
    off_y <= p.oy;
    tex_r <= p.tr;
    tex_g <= p.tg;
    tex_b <= p.tb;
    dst_r <= p.dr;
    dst_g <= p.dg;
    dst_b <= p.db;
    end_of_candidate <= p.eoc;
    end_of_search <= p.eos;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_pair(p);
    n_items++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (best_q.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MODE:   cfg_mode = val[MODE_W-1:0];
      REG_OVL:    cfg_ovl = val[OVL_W-1:0];
      REG_TILE_W: cfg_tw = val;
      REG_TILE_H: cfg_th = val;
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_cfg(input logic [MODE_W-1:0] mode, input logic [OVL_W-1:0] ovl,
                           input logic [TILE_DIM_W-1:0] tw, input logic [TILE_DIM_W-1:0] th);
    set_reg(REG_MODE, CFG_DATA_W'(mode));
    set_reg(REG_OVL, CFG_DATA_W'(ovl));
    set_reg(REG_TILE_W, tw);
    set_reg(REG_TILE_H, th);
  endtask

  function automatic pix_pair_t mk_pair(input int cx, input int cy, input int ox, input int oy,
                                        input int tr, input int tg, input int tb,
                                        input int dr, input int dg, input int db,
                                        input bit eoc, input bit eos);
    pix_pair_t p;
    p.cx = POS_W'(cx); p.cy = POS_W'(cy); p.ox = OFF_W'(ox); p.oy = OFF_W'(oy);
    p.tr = PIX_W'(tr); p.tg = PIX_W'(tg); p.tb = PIX_W'(tb);
    p.dr = PIX_W'(dr); p.dg = PIX_W'(dg); p.db = PIX_W'(db);
    p.eoc = eoc; p.eos = eos;
    return p;
  endfunction

  // random pixel, mostly inside the configured tile
  function automatic pix_pair_t rand_pair();
    pix_pair_t p;
    int        lw, lh;
    lw = (cfg_tw == 0) ? 1 : (cfg_tw > MAX_TILE) ? MAX_TILE : int'(cfg_tw);
    lh = (cfg_th == 0) ? 1 : (cfg_th > MAX_TILE) ? MAX_TILE : int'(cfg_th);
    p.cx = POS_W'($urandom);
    p.cy = POS_W'($urandom);
    p.ox = OFF_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                               : $urandom_range(0, lw - 1));
    p.oy = OFF_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                               : $urandom_range(0, lh - 1));
    p.tr = PIX_W'($urandom);
    p.tg = PIX_W'($urandom);
    p.tb = PIX_W'($urandom);
    p.dr = ($urandom_range(0, 7) == 0) ? p.tr : PIX_W'($urandom);
    p.dg = ($urandom_range(0, 7) == 0) ? p.tg : PIX_W'($urandom);
    p.db = ($urandom_range(0, 7) == 0) ? p.tb : PIX_W'($urandom);
    p.eoc = 1'b0;
    p.eos = 1'b0;
    return p;
  endfunction

  // one search; a repeated pixel list gives an exact cost tie, an open end merges candidates
  task automatic run_search(input int ncand, input int max_pix);
    pix_pair_t        prev[$];
    pix_pair_t        cur[$];
    pix_pair_t        p;
    logic [POS_W-1:0] cx, cy;
    int               npix;
    for (int c = 0; c < ncand; c++) begin
      cx = POS_W'($urandom);
      cy = POS_W'($urandom);
      cur.delete();
      if (c > 0 && $urandom_range(0, 3) == 0) begin
        cur = prev;
      end else begin
        npix = $urandom_range(1, max_pix);
        for (int i = 0; i < npix; i++) cur.push_back(rand_pair());
      end
      for (int i = 0; i < cur.size(); i++) begin
        p = cur[i];
        p.cx = cx;
        p.cy = cy;
        p.eoc = 1'b0;
        p.eos = 1'b0;
        if (i == cur.size() - 1) begin
          p.eos = (c == ncand - 1);
          p.eoc = p.eos ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) != 0);
        end
        send_pair(p);
      end
      prev = cur;
    end
  endtask

  task automatic test_reset_config();
    // strip edges, corner counted once, ties, search end without candidate end
    send_pair(mk_pair(0, 0, 0, 0, 255, 255, 255, 0, 0, 0, 0, 0));
    send_pair(mk_pair(0, 0, 63, 63, 0, 0, 0, 255, 255, 255, 1, 0));
    send_pair(mk_pair(4095, 4095, 5, 35, 255, 0, 0, 0, 0, 0, 1, 0));
    send_pair(mk_pair(2048, 1024, 35, 5, 0, 0, 255, 0, 0, 0, 1, 0));
    send_pair(mk_pair(1, 2, 6, 6, 128, 128, 128, 127, 127, 127, 0, 1));
    send_pair(mk_pair(4095, 0, 0, 5, 170, 85, 170, 85, 170, 85, 1, 1));
    send_pair(mk_pair(0, 4095, 36, 0, 255, 255, 255, 0, 0, 0, 0, 0));
    send_pair(mk_pair(0, 4095, 0, 36, 255, 255, 255, 0, 0, 0, 0, 0));
    send_pair(mk_pair(0, 4095, 6, 35, 255, 255, 255, 0, 0, 0, 0, 0));
    send_pair(mk_pair(0, 4095, 35, 5, 1, 1, 1, 0, 0, 0, 1, 0));
    send_pair(mk_pair(7, 7, 5, 35, 0, 0, 0, 2, 2, 2, 0, 0));
    send_pair(mk_pair(7, 7, 3, 3, 9, 9, 9, 9, 9, 9, 1, 1));
    settle();
  endtask

  task automatic test_register_extremes();
    apply_cfg(MODE_TOP, 1, 2, 2);
    run_search(3, 4);
    settle();
    apply_cfg(MODE_LEFT, 63, 64, 64);
    run_search(3, 6);
    settle();
    apply_cfg(MODE_ALIAS, 6, 100, 127);
    run_search(3, 6);
    settle();
    apply_cfg(MODE_BOTH, 0, 0, 64);
    run_search(2, 4);
    settle();
    apply_cfg(MODE_BOTH, 63, 127, 2);
    run_search(3, 5);
    settle();
  endtask

  // top rows of the largest tile, worst-case colors: one long high-cost candidate
  task automatic test_full_tile();
    apply_cfg(MODE_BOTH, 63, 64, 64);
    for (int y = 0; y < FULL_ROWS; y++)
      for (int x = 0; x < MAX_TILE; x++)
        send_pair(mk_pair(4095, 4095, x, y, 255, 0, 255, 0, 255, 0,
                          (x == MAX_TILE - 1 && y == FULL_ROWS - 1),
                          (x == MAX_TILE - 1 && y == FULL_ROWS - 1)));
    settle();
  endtask

  task automatic test_random_searches();
    int stop_at;
    stop_at = n_items + RANDOM_ITEMS;
    while (n_items < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        settle();
        apply_cfg(MODE_W'($urandom_range(0, 3)),
                  OVL_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(1, 8)),
                  TILE_DIM_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                          : $urandom_range(2, 16)),
                  TILE_DIM_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                          : $urandom_range(2, 16)));
      end
      quiet = ($urandom_range(0, 5) == 0);
      run_search($urandom_range(1, 6), ($urandom_range(0, 7) == 0) ? 40 : 8);
    end
    quiet = 1'b0;
    settle();
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left = burst_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    best_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      n_results++;
      if (best_q.size() == 0) begin
        $error("result transfer with no search pending: x %0d y %0d cost %0d",
               best_x, best_y, best_cost);
        n_fail++;
      end else begin
        want = best_q.pop_front();
        if (best_x !== want.x) begin
          $error("best_x: expected %0d, got %0d", want.x, best_x);
          n_fail++;
        end
        if (best_y !== want.y) begin
          $error("best_y: expected %0d, got %0d", want.y, best_y);
          n_fail++;
        end
        if (best_cost !== want.cost) begin
          $error("best_cost: expected %0d, got %0d", want.cost, best_cost);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles, best_q.size());
      $display("overlap_ssd_best_patch_search_tb failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    cand_x = '0;
    cand_y = '0;
    off_x = '0;
    off_y = '0;
    tex_r = '0;
    tex_g = '0;
    tex_b = '0;
    dst_r = '0;
    dst_g = '0;
    dst_b = '0;
    end_of_candidate = 1'b0;
    end_of_search = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_config();
    test_register_extremes();
    test_full_tile();
    test_random_searches();

    $display("covered %0d pixel transfers in %0d searches, %0d config writes, all modes",
             n_items, n_searches, n_writes);
    $display("%0d best-patch results checked, %0d mismatches", n_results, n_fail);
    if (n_fail == 0 && best_q.size() == 0)
      $display("overlap_ssd_best_patch_search_tb passed");
    else
      $display("overlap_ssd_best_patch_search_tb failed");
    $finish;
  end

endmodule
